// ===== src/tcce_pkg.sv =====
// ----------------------------------------------------------------------------
// tcce_pkg: shared constants for the text console cursor engine
// Grid geometry, command codes and character constants.
// ----------------------------------------------------------------------------
`default_nettype none
package tcce_pkg;
  localparam int COLUMNS = 120;
  localparam int ROWS    = 45;
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int ROW_W   = $clog2(ROWS);
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int ADDR_W  = $clog2(CELLS);

  localparam logic [3:0] OP_PUT    = 4'd0;
  localparam logic [3:0] OP_LEFT   = 4'd1;
  localparam logic [3:0] OP_RIGHT  = 4'd2;
  localparam logic [3:0] OP_UP     = 4'd3;
  localparam logic [3:0] OP_DOWN   = 4'd4;
  localparam logic [3:0] OP_BKSP   = 4'd5;
  localparam logic [3:0] OP_DEL    = 4'd6;
  localparam logic [3:0] OP_INS    = 4'd7;
  localparam logic [3:0] OP_CLEAR  = 4'd8;
  localparam logic [3:0] OP_READ   = 4'd9;

  localparam logic [6:0] CH_SPACE   = 7'd32;
  localparam logic [7:0] CH_NEWLINE = 8'd10;

  // Memory access request from the sequencer.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [6:0]        wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;
endpackage
`default_nettype wire

// ===== src/tcce_grid_ram.sv =====
// ----------------------------------------------------------------------------
// tcce_grid_ram: character grid storage
// One write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module tcce_grid_ram
  import tcce_pkg::*;
(
  input  wire logic       clk,
  input  wire mem_req_t   req,
  output logic [6:0]      rdata
);
  logic [6:0] mem [CELLS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end
endmodule
`default_nettype wire

// ===== src/text_console_cursor_engine_core.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor_engine_core: text console grid and cursor
// Sequencer that edits a character grid memory with read-modify-write sweeps.
// ----------------------------------------------------------------------------
//  channel | dir | tdata fields (low bit up)               | tuser
//  s_axis  | in  | opcode[3:0] char_code[11:4]              | -
//          |     | read_row[17:12] read_col[24:18]          |
//  m_axis  | out | cursor_col[6:0] cursor_row[12:7]         | -
//          |     | cell_char[19:13]                         |
// Cursor moves and puts go from idle straight to the output state; a read
// passes through a read state first. Insert and delete sweep the row, one
// cell per cycle. Scroll copies the grid up one row, one cell per cycle; clear
// writes every cell. During the clearing pass after reset, s_axis_tready is low.
// The result register holds while m_axis_tready is low; no new item is taken
// until it is gone.
// ----------------------------------------------------------------------------
`default_nettype none
module text_console_cursor_engine_core
  import tcce_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // opcode, char_code, read_row, read_col
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata   // cursor_col, cursor_row, cell_char
);
  localparam logic [2:0] ST_CLR   = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SHIFT = 3'd2; // read-ahead copy, delete/scroll
  localparam logic [2:0] ST_INS   = 3'd3; // copy backwards
  localparam logic [2:0] ST_RD    = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;
  localparam logic [2:0] ST_FILL  = 3'd6; // blank fill to end address

  logic [2:0]        state;
  logic [COL_W-1:0]  cx;
  logic [ROW_W-1:0]  cy;
  logic [6:0]        cell_char;
  logic [ADDR_W-1:0] ptr;      // next address to write
  logic [ADDR_W-1:0] last;     // final address of the sweep
  logic              primed;   // read data for ptr is valid
  logic              scroll;   // shift distance is one whole row
  logic              rd_ok;
  mem_req_t          req;
  logic [6:0]        rdata;

  logic [3:0]        op;
  logic [7:0]        ch;
  logic [5:0]        rrow;
  logic [6:0]        rcol;
  logic [ADDR_W-1:0] row_base;
  logic [ADDR_W-1:0] cur_addr;
  logic              printable;

  assign op   = s_axis_tdata[3:0];
  assign ch   = s_axis_tdata[11:4];
  assign rrow = s_axis_tdata[17:12];
  assign rcol = s_axis_tdata[24:18];
  assign row_base  = ADDR_W'(cy * COLUMNS);
  assign cur_addr  = row_base + ADDR_W'(cx);
  assign printable = (ch >= 8'd32) && (ch <= 8'd127);

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata  = {4'd0, cell_char, 6'(cy), 7'(cx)};

  tcce_grid_ram u_ram (.clk(clk), .req(req), .rdata(rdata));

  // Memory request
  always_comb begin
    req.we    = 1'b0;
    req.waddr = ptr;
    req.wdata = CH_SPACE;
    req.raddr = ptr + ADDR_W'(1);
    unique case (state)
      ST_CLR, ST_FILL: req.we = 1'b1;
      ST_SHIFT: begin
        // source runs one cell (delete) or one row (scroll) ahead of ptr
        req.raddr = ptr + (scroll ? ADDR_W'(COLUMNS) : ADDR_W'(1)) + ADDR_W'(primed);
        req.we    = primed;
        if (scroll) begin
          req.wdata = (ptr >= ADDR_W'(CELLS - COLUMNS)) ? CH_SPACE : rdata;
        end else begin
          req.wdata = (ptr == last) ? CH_SPACE : rdata;
        end
      end
      ST_INS: begin
        req.raddr = primed ? (ptr - ADDR_W'(2)) : (ptr - ADDR_W'(1));
        req.we    = primed;
        req.wdata = (ptr == last) ? CH_SPACE : rdata;
      end
      ST_RD: req.raddr = ptr;
      default: begin
        req.raddr = ADDR_W'(rrow * COLUMNS) + ADDR_W'(rcol);
        req.we    = (state == ST_IDLE) && s_axis_tvalid && (op == OP_PUT) && printable;
        req.waddr = cur_addr;
        req.wdata = ch[6:0];
      end
    endcase
  end

  // Whether advancing down one row must scroll at the bottom
  function automatic logic scroll_needed(input logic [ROW_W-1:0] y);
    scroll_needed = (32'(y) + 1 >= ROWS);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      cx        <= '0;
      cy        <= '0;
      ptr       <= '0;
      last      <= ADDR_W'(CELLS - 1);
      primed    <= 1'b0;
      scroll    <= 1'b0;
      cell_char <= '0;
      rd_ok     <= 1'b0;
    end else begin
      unique case (state)
        ST_CLR, ST_FILL: begin
          ptr <= ptr + ADDR_W'(1);
          if (ptr == last) state <= (state == ST_CLR) ? ST_IDLE : ST_OUT;
        end
        ST_SHIFT: begin
          primed <= 1'b1;
          if (primed) begin
            ptr <= ptr + ADDR_W'(1);
            if (ptr == last) state <= ST_OUT;
          end
        end
        ST_INS: begin
          primed <= 1'b1;
          if (primed) begin
            ptr <= ptr - ADDR_W'(1);
            if (ptr == last) state <= ST_OUT;
          end
        end
        ST_RD: begin
          state     <= ST_OUT;
          cell_char <= rd_ok ? rdata : 7'd0;
        end
        ST_OUT: if (m_axis_tready) state <= ST_IDLE;
        default: if (s_axis_tvalid) begin
          cell_char <= '0;
          primed    <= 1'b0;
          scroll    <= 1'b0;
          state     <= ST_OUT;
          unique case (op)
            OP_PUT: begin
              if (ch == CH_NEWLINE || printable) begin
                logic wrap;
                wrap = (ch == CH_NEWLINE) || (32'(cx) + 1 >= COLUMNS);
                if (wrap) begin
                  cx <= '0;
                  if (scroll_needed(cy)) begin
                    ptr <= '0; last <= ADDR_W'(CELLS - 1); scroll <= 1'b1;
                    state <= ST_SHIFT;
                  end else cy <= cy + ROW_W'(1);
                end else cx <= cx + COL_W'(1);
              end
            end
            OP_RIGHT, OP_DOWN: begin
              if (op == OP_DOWN || 32'(cx) + 1 >= COLUMNS) begin
                if (op == OP_RIGHT) cx <= '0;
                if (scroll_needed(cy)) begin
                  ptr <= '0; last <= ADDR_W'(CELLS - 1); scroll <= 1'b1;
                  state <= ST_SHIFT;
                end else cy <= cy + ROW_W'(1);
              end else cx <= cx + COL_W'(1);
            end
            OP_LEFT: begin
              if (cx == '0) begin
                cx <= COL_W'(COLUMNS - 1);
                if (cy != '0) cy <= cy - ROW_W'(1);
              end else cx <= cx - COL_W'(1);
            end
            OP_UP: if (cy != '0) cy <= cy - ROW_W'(1);
            OP_BKSP: if (cx != '0) begin
              cx    <= cx - COL_W'(1);
              ptr   <= cur_addr - ADDR_W'(1);
              last  <= row_base + ADDR_W'(COLUMNS - 1);
              state <= ST_SHIFT;
            end
            OP_DEL: begin
              ptr   <= cur_addr;
              last  <= row_base + ADDR_W'(COLUMNS - 1);
              state <= ST_SHIFT;
            end
            OP_INS: begin
              ptr   <= row_base + ADDR_W'(COLUMNS - 1);
              last  <= cur_addr;
              state <= ST_INS;
            end
            OP_CLEAR: begin
              cx <= '0; cy <= '0;
              ptr <= '0; last <= ADDR_W'(CELLS - 1);
              state <= ST_FILL;
            end
            OP_READ: begin
              ptr   <= ADDR_W'(rrow * COLUMNS) + ADDR_W'(rcol);
              rd_ok <= (32'(rrow) < ROWS) && (32'(rcol) < COLUMNS);
              state <= ST_RD;
            end
            default: ;
          endcase
        end
      endcase
    end
  end
endmodule
`default_nettype wire
